// ===== sv/sorted_set_insert_delete_core_defines.svh =====
// Assertion macros shared by the sorted set core RTL.
// Each macro expects i_clk and i_rst_n in scope of the module that uses it.
`ifndef SORTED_SET_INSERT_DELETE_CORE_DEFINES_SVH
`define SORTED_SET_INSERT_DELETE_CORE_DEFINES_SVH

// Same-cycle implication, checked only out of reset.
`define SSID_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ssid check failed");

// Next-cycle implication, checked only out of reset.
`define SSID_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ssid check failed");

`endif

// ===== sv/ssid_pkg.sv =====
// Shared types and constants of the sorted set core.
// No dependencies; used by ssid_cell and sorted_set_insert_delete_core.
`timescale 1ns / 1ps
`default_nettype none

package ssid_pkg;

    localparam int CAPACITY = 64;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int VAL_W    = 32;
    localparam int STAT_W   = 3;
    localparam int OCNT_W   = 7;
    localparam int OUT_W    = 16;

    typedef logic signed [VAL_W-1:0] t_value;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_DELETE = 1'b1;

    typedef enum logic [STAT_W-1:0] {
        ST_INSERTED  = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_DELETED   = 3'd2,
        ST_NOTFOUND  = 3'd3,
        ST_FULL      = 3'd4
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_UPD  = 1'b1
    } t_state;

    // Broadcast to every cell during the update cycle.
    typedef struct packed {
        logic   ins;
        logic   del;
        t_value key;
    } t_cell_ctl;

endpackage

`default_nettype wire

// ===== sv/ssid_cell.sv =====
// One slot of the sorted register chain: holds a value and its compare flags.
// Depends on ssid_pkg; instantiated in a row by sorted_set_insert_delete_core.
`timescale 1ns / 1ps
`default_nettype none

module ssid_cell (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cmp_en,
    input  wire ssid_pkg::t_value    i_cmp_key,
    input  wire logic                i_occ,
    input  wire ssid_pkg::t_cell_ctl i_ctl,
    input  wire logic                i_left_lt,
    input  wire ssid_pkg::t_value    i_left_val,
    input  wire ssid_pkg::t_value    i_right_val,
    output ssid_pkg::t_value         o_val,
    output logic                     o_lt,
    output logic                     o_eq
);

    ssid_pkg::t_value r_val;
    ssid_pkg::t_value n_val;
    logic             r_lt;
    logic             r_eq;

    // Cells below the key keep their value; the first cell not below it is
    // the insert or delete point, and everything above moves one way or the other.
    always_comb begin
        n_val = r_val;
        if (i_ctl.ins && !r_lt) begin
            n_val = i_left_lt ? i_ctl.key : i_left_val;
        end else if (i_ctl.del && !r_lt) begin
            n_val = i_right_val;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lt <= 1'b0;
            r_eq <= 1'b0;
        end else if (i_cmp_en) begin
            r_lt <= i_occ && (r_val < i_cmp_key);
            r_eq <= i_occ && (r_val == i_cmp_key);
        end
    end

    assign o_val = r_val;
    assign o_lt  = r_lt;
    assign o_eq  = r_eq;

endmodule

`default_nettype wire

// ===== sv/sorted_set_insert_delete_core.sv =====
// Sorted set of up to CAPACITY distinct signed 32-bit values, kept in a chain
// of register cells in ascending order. In the cycle an item is accepted every
// cell compares its value with the key at once; then, in the update state,
// every cell shifts left, right or holds in parallel and the result item is
// written to the output register. A new item is accepted while a result still
// waits; the update cycle stalls only if the output register is still full.
// No clearing pass is needed after reset.
`timescale 1ns / 1ps
`default_nettype none
`include "sorted_set_insert_delete_core_defines.svh"

module sorted_set_insert_delete_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [31:0] i_s_tdata,   // [31:0] value (signed)
    input  wire logic        i_s_tuser,   // [0] cmd: 0 insert, 1 delete
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [15:0]      o_m_tdata    // [2:0] status, [9:3] count, rest zero
);

    localparam int N  = ssid_pkg::CAPACITY;
    localparam int CW = ssid_pkg::CNT_W;

    ssid_pkg::t_state r_state;
    ssid_pkg::t_state n_state;
    logic             r_cmd;
    ssid_pkg::t_value r_key;
    logic [CW-1:0]    r_count;
    logic [CW-1:0]    n_count;
    logic             r_m_tvalid;
    logic             n_m_tvalid;
    logic [15:0]      r_m_tdata;
    logic [15:0]      n_m_tdata;

    logic                        s_accept;
    logic                        out_free;
    logic                        upd_go;
    logic                        found;
    logic                        full;
    ssid_pkg::t_status           status;
    ssid_pkg::t_cell_ctl         ctl;
    logic [ssid_pkg::OCNT_W-1:0] cnt_ext;

    ssid_pkg::t_value w_val [N];
    logic [N-1:0]     w_lt;
    logic [N-1:0]     w_eq;

    assign s_accept = i_s_tvalid && o_s_tready;
    assign out_free = !r_m_tvalid || i_m_tready;
    assign found    = |w_eq;
    assign full     = (r_count == CW'(N));

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ssid_pkg::S_IDLE: begin
                if (s_accept) begin
                    n_state = ssid_pkg::S_UPD;
                end
            end
            ssid_pkg::S_UPD: begin
                if (out_free) begin
                    n_state = ssid_pkg::S_IDLE;
                end
            end
            default: n_state = ssid_pkg::S_IDLE;
        endcase
    end

    // State outputs.
    always_comb begin
        o_s_tready = 1'b0;
        upd_go     = 1'b0;
        case (r_state)
            ssid_pkg::S_IDLE: o_s_tready = 1'b1;
            ssid_pkg::S_UPD:  upd_go     = out_free;
            default: begin
                o_s_tready = 1'b0;
                upd_go     = 1'b0;
            end
        endcase
    end

    always_comb begin
        ctl.key = r_key;
        ctl.ins = 1'b0;
        ctl.del = 1'b0;
        n_count = r_count;
        if (r_cmd == ssid_pkg::CMD_INSERT) begin
            if (found) begin
                status = ssid_pkg::ST_DUPLICATE;
            end else if (full) begin
                status = ssid_pkg::ST_FULL;
            end else begin
                status  = ssid_pkg::ST_INSERTED;
                ctl.ins = upd_go;
                n_count = r_count + CW'(1);
            end
        end else begin
            if (found) begin
                status  = ssid_pkg::ST_DELETED;
                ctl.del = upd_go;
                n_count = r_count - CW'(1);
            end else begin
                status = ssid_pkg::ST_NOTFOUND;
            end
        end
        if (!upd_go) begin
            n_count = r_count;
        end
    end

    assign cnt_ext = ssid_pkg::OCNT_W'(n_count);

    always_comb begin
        n_m_tvalid = r_m_tvalid && !i_m_tready;
        n_m_tdata  = r_m_tdata;
        if (upd_go) begin
            n_m_tvalid = 1'b1;
            n_m_tdata  = {6'd0, cnt_ext, status};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ssid_pkg::S_IDLE;
            r_count    <= '0;
            r_m_tvalid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_m_tvalid <= n_m_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m_tdata <= n_m_tdata;
        if (s_accept) begin
            r_cmd <= i_s_tuser;
            r_key <= i_s_tdata;
        end
    end

    genvar g;
    generate
        for (g = 0; g < N; g++) begin : g_cell
            localparam logic [CW-1:0] IDX = CW'(g);
            logic             left_lt;
            ssid_pkg::t_value left_val;
            ssid_pkg::t_value right_val;

            if (g == 0) begin : g_head
                assign left_lt  = 1'b1;
                assign left_val = '0;
            end else begin : g_mid
                assign left_lt  = w_lt[g-1];
                assign left_val = w_val[g-1];
            end
            if (g == N - 1) begin : g_tail
                assign right_val = '0;
            end else begin : g_body
                assign right_val = w_val[g+1];
            end

            ssid_cell u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_cmp_en    (s_accept),
                .i_cmp_key   (i_s_tdata),
                .i_occ       (IDX < r_count),
                .i_ctl       (ctl),
                .i_left_lt   (left_lt),
                .i_left_val  (left_val),
                .i_right_val (right_val),
                .o_val       (w_val[g]),
                .o_lt        (w_lt[g]),
                .o_eq        (w_eq[g])
            );
        end
    endgenerate

    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = r_m_tdata;

    `SSID_ASSERT_NOW(a_count_bound, 1'b1, r_count <= CW'(N))
    `SSID_ASSERT_NOW(a_one_match, r_state == ssid_pkg::S_UPD, $onehot0(w_eq))
    `SSID_ASSERT_NEXT(a_count_idle, r_state == ssid_pkg::S_IDLE, $stable(r_count))
    `SSID_ASSERT_NOW(a_full_status, upd_go && status == ssid_pkg::ST_FULL, r_count == CW'(N))

endmodule

`default_nettype wire

// ===== tb/sorted_set_insert_delete_core_tb.sv =====
// Self-checking testbench for sorted_set_insert_delete_core: insert and delete items
// are checked against a sorted-table predictor. Depends on ssid_pkg and the core RTL.
`timescale 1ns / 1ps

module sorted_set_insert_delete_core_tb;

    localparam int CYCLE_LIMIT = 200000;

    typedef struct {
        logic             cmd;
        ssid_pkg::t_value value;
    } t_request;

    typedef struct {
        ssid_pkg::t_status status;
        logic [6:0]        count;
    } t_outcome;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [31:0] i_s_tdata = '0;   // [31:0] value (signed)
    logic        i_s_tuser = 1'b0; // [0] cmd: 0 insert, 1 delete
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [15:0] o_m_tdata;        // [2:0] status, [9:3] count, rest zero

    sorted_set_insert_delete_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    t_request         pending_q[$];
    t_outcome         outcome_q[$];
    ssid_pkg::t_value mirror_q[$];  // what the stimulus generator believes is stored

    ssid_pkg::t_value table_vals[ssid_pkg::CAPACITY];
    int               table_size = 0;

    int       fail_count = 0;
    int       cycle_count = 0;
    int       items_in = 0;
    logic     in_fire = 1'b0;
    t_request drive_req;
    t_outcome want_res;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Sorted-table predictor: one outcome per accepted item.
    function automatic t_outcome apply_op(input logic cmd, input ssid_pkg::t_value key);
        t_outcome r;
        int       pos;
        bit       hit;
        pos = 0;
        while (pos < table_size && table_vals[pos] < key) pos++;
        hit = (pos < table_size) && (table_vals[pos] == key);
        if (cmd == ssid_pkg::CMD_INSERT) begin
            if (hit) begin
                r.status = ssid_pkg::ST_DUPLICATE;
            end else if (table_size >= ssid_pkg::CAPACITY) begin
                r.status = ssid_pkg::ST_FULL;
            end else begin
                for (int j = table_size; j > pos; j--) table_vals[j] = table_vals[j-1];
                table_vals[pos] = key;
                table_size++;
                r.status = ssid_pkg::ST_INSERTED;
            end
        end else begin
            if (hit) begin
                for (int j = pos; j + 1 < table_size; j++) table_vals[j] = table_vals[j+1];
                table_size--;
                r.status = ssid_pkg::ST_DELETED;
            end else begin
                r.status = ssid_pkg::ST_NOTFOUND;
            end
        end
        r.count = 7'(table_size);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int want, input int got);
        fail_count++;
        $display("ERROR @%0t: %s: expected %0d, got %0d", $realtime, what, want, got);
    endtask

    function automatic int mirror_find(input ssid_pkg::t_value v);
        for (int i = 0; i < mirror_q.size(); i++)
            if (mirror_q[i] == v) return i;
        return -1;
    endfunction

    task automatic add_req(input logic cmd, input ssid_pkg::t_value v);
        t_request r;
        int       idx;
        r.cmd = cmd;
        r.value = v;
        pending_q.push_back(r);
        idx = mirror_find(v);
        if (cmd == ssid_pkg::CMD_INSERT && idx < 0 && mirror_q.size() < ssid_pkg::CAPACITY)
            mirror_q.push_back(v);
        else if (cmd == ssid_pkg::CMD_DELETE && idx >= 0)
            mirror_q.delete(idx);
    endtask

    function automatic ssid_pkg::t_value rand_key();
        case ($urandom_range(0, 9))
            6, 7:    return ssid_pkg::t_value'($urandom_range(0, 16)) - 8;
            8: begin
                case ($urandom_range(0, 2))
                    0:       return 32'sh8000_0000;
                    1:       return 32'sh7fff_ffff;
                    default: return 32'sh8000_0001;
                endcase
            end
            9:       return $urandom_range(0, 1) ? 32'sh7fff_fffe : -32'sd1;
            default: return ssid_pkg::t_value'($urandom);
        endcase
    endfunction

    function automatic ssid_pkg::t_value pick_stored();
        if (mirror_q.size() == 0) return rand_key();
        return mirror_q[$urandom_range(0, mirror_q.size() - 1)];
    endfunction

    // Fill the table past capacity, then drain it to empty and beyond.
    task automatic gen_episode();
        int r;
        while (mirror_q.size() < ssid_pkg::CAPACITY) begin
            r = $urandom_range(0, 99);
            if (r < 72)      add_req(ssid_pkg::CMD_INSERT, rand_key());
            else if (r < 85) add_req(ssid_pkg::CMD_INSERT, pick_stored());
            else if (r < 95) add_req(ssid_pkg::CMD_DELETE, pick_stored());
            else             add_req(ssid_pkg::CMD_DELETE, rand_key());
        end
        repeat (12) begin
            r = $urandom_range(0, 99);
            if (r < 40) begin
                add_req(ssid_pkg::CMD_INSERT, rand_key());
            end else if (r < 80) begin
                add_req(ssid_pkg::CMD_INSERT, pick_stored());
            end else begin
                add_req(ssid_pkg::CMD_DELETE, pick_stored());
                add_req(ssid_pkg::CMD_INSERT, rand_key());
            end
        end
        while (mirror_q.size() > 0) begin
            r = $urandom_range(0, 99);
            if (r < 70)      add_req(ssid_pkg::CMD_DELETE, pick_stored());
            else if (r < 80) add_req(ssid_pkg::CMD_DELETE, rand_key());
            else if (r < 90) add_req(ssid_pkg::CMD_INSERT, pick_stored());
            else             add_req(ssid_pkg::CMD_INSERT, rand_key());
        end
        repeat (3) add_req(ssid_pkg::CMD_DELETE, rand_key());
    endtask

    // A stretch of items in the middle of the run gets no idling on either side.
    function automatic bit go_quiet();
        if (items_in >= 500 && items_in < 700) return 1'b0;
        return $urandom_range(0, 99) < 28;
    endfunction

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= !go_quiet();
            if (!i_s_tvalid || in_fire) begin
                if (pending_q.size() > 0 && !go_quiet()) begin
                    drive_req = pending_q.pop_front();
                    i_s_tvalid <= 1'b1;
                    i_s_tdata  <= drive_req.value;
                    i_s_tuser  <= drive_req.cmd;
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else if (!i_rst_n) begin
            in_fire <= 1'b0;
        end else begin
            in_fire <= i_s_tvalid && o_s_tready;
            if (o_m_tvalid && i_m_tready) begin
                if (outcome_q.size() == 0) begin
                    report_mismatch("result item with none pending", -1, o_m_tdata);
                end else begin
                    want_res = outcome_q.pop_front();
                    if (o_m_tdata[2:0] !== want_res.status)
                        report_mismatch("status", want_res.status, o_m_tdata[2:0]);
                    if (o_m_tdata[9:3] !== want_res.count)
                        report_mismatch("count", want_res.count, o_m_tdata[9:3]);
                    if (o_m_tdata[15:10] !== 6'd0)
                        report_mismatch("padding bits", 0, o_m_tdata[15:10]);
                end
            end
            if (i_s_tvalid && o_s_tready) begin
                outcome_q.push_back(apply_op(i_s_tuser, i_s_tdata));
                items_in++;
            end
        end
    end

    initial begin
        // Directed items: empty table, extreme values, head and tail edits.
        add_req(ssid_pkg::CMD_DELETE, 32'sd5);
        add_req(ssid_pkg::CMD_INSERT, 32'sd0);
        add_req(ssid_pkg::CMD_INSERT, 32'sh7fff_ffff);
        add_req(ssid_pkg::CMD_INSERT, 32'sh8000_0000);
        add_req(ssid_pkg::CMD_INSERT, -32'sd1);
        add_req(ssid_pkg::CMD_INSERT, 32'sd0);
        add_req(ssid_pkg::CMD_DELETE, 32'sh7fff_ffff);
        add_req(ssid_pkg::CMD_INSERT, 32'sd100);
        add_req(ssid_pkg::CMD_DELETE, 32'sh8000_0000);
        add_req(ssid_pkg::CMD_DELETE, 32'sd7);
        add_req(ssid_pkg::CMD_INSERT, 32'sh5555_5555);
        add_req(ssid_pkg::CMD_INSERT, 32'shAAAA_AAAA);
        add_req(ssid_pkg::CMD_DELETE, 32'sh5555_5555);
        add_req(ssid_pkg::CMD_DELETE, 32'shAAAA_AAAA);
        add_req(ssid_pkg::CMD_DELETE, 32'sd100);
        add_req(ssid_pkg::CMD_DELETE, -32'sd1);
        add_req(ssid_pkg::CMD_DELETE, 32'sd0);
        add_req(ssid_pkg::CMD_DELETE, 32'sd0);
        add_req(ssid_pkg::CMD_INSERT, 32'sh8000_0000);
        add_req(ssid_pkg::CMD_DELETE, 32'sh8000_0000);

        repeat (6) gen_episode();
        repeat (120) begin
            if ($urandom_range(0, 1))
                add_req(logic'($urandom_range(0, 1)), rand_key());
            else
                add_req(logic'($urandom_range(0, 1)), pick_stored());
        end

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_q.size() > 0 || i_s_tvalid || outcome_q.size() > 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (outcome_q.size() != 0)
            report_mismatch("result items never delivered", 0, outcome_q.size());

        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+sv
sv/ssid_pkg.sv
sv/ssid_cell.sv
sv/sorted_set_insert_delete_core.sv
tb/sorted_set_insert_delete_core_tb.sv
